/* src/lssr_pkg.sv */
// ----------------------------------------------------------------------------
// lssr_pkg
// Shared types and constants of the looping step sequencer and recorder.
// ----------------------------------------------------------------------------
package lssr_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_REC   = 2'd2,
    KIND_BARS  = 2'd3
  } kind_t;

  // one slot: {on, freq[15:0], sample[7:0]}
  localparam int SLOT_W   = 25;
  localparam int SLOT_ON  = 24;
  localparam int FREQ_W   = 16;
  localparam int SAMPLE_W = 8;

  // shared serial divider widths
  localparam int NUM_W = 42;
  localparam int DEN_W = 25;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

/* src/looping_step_sequencer_recorder.sv */
// ----------------------------------------------------------------------------
// looping_step_sequencer_recorder
// Looping step sequencer with loop recorder, event table held in one memory.
//
//   channel   ports                                         transfer
//   input     start, busy, kind, event_freq, event_sample,  start & !busy
//             quant_reso, bar_count
//   result    strobe, note_freq, note_sample, last_of_run   strobe
//   config    cfg_we, cfg_wdata (ms_per_step)               cfg_we
//
// tick: two passes of the shared serial divider, then one row read and one
//   strobe per emitted note (none if the new step is empty); no row read
//   if the step is unchanged
// record: same divider passes, row read, row write if a slot is free
// set bars: a read and a write per copied row; start clock: stays idle
// reset clears the row valid bits at once, no clearing pass
// results are not held: one strobe per note, the receiver cannot stall
// ----------------------------------------------------------------------------
module looping_step_sequencer_recorder import lssr_pkg::*; #(
  parameter int STEPS_PER_BAR   = 16,
  parameter int MAX_BARS        = 8,
  parameter int EVENTS_PER_STEP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [15:0] event_freq,
  input  logic [7:0]  event_sample,
  input  logic [7:0]  quant_reso,
  input  logic [3:0]  bar_count,
  output logic        strobe,
  output logic [15:0] note_freq,
  output logic [7:0]  note_sample,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int TOTAL = STEPS_PER_BAR * MAX_BARS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int LW    = $clog2(TOTAL + 1);
  localparam int BW    = $clog2(MAX_BARS + 1);
  localparam int E     = EVENTS_PER_STEP;
  localparam int RW    = E * SLOT_W;
  localparam int SW    = (E > 1) ? $clog2(E) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RPREP = 9'b000000010,
    S_DIVQ  = 9'b000000100,
    S_DIVM  = 9'b000001000,
    S_READ  = 9'b000010000,
    S_EMIT  = 9'b000100000,
    S_COPYR = 9'b001000000,
    S_COPYW = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state;
  logic          op_tick;
  logic [31:0]   elapsed;
  logic [AW-1:0] prev;
  logic [BW-1:0] loop_bars;
  logic [15:0]   rec_count;
  logic [15:0]   ms_per_step;
  logic [7:0]    q_r;
  logic [15:0]   freq_r;
  logic [7:0]    sample_r;
  logic [23:0]   d_r;
  logic [AW-1:0] step_r;
  logic [E-1:0]  mask;
  logic [RW-1:0] row_r;
  logic [AW-1:0] base_r;
  logic [LW-1:0] ci;
  logic [LW-1:0] count_r;

  logic [15:0]   period;
  logic [7:0]    q_in;
  logic [BW-1:0] n_req;
  logic [LW-1:0] loop_len;
  logic [AW-1:0] step_c;

  logic             div_go;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;

  logic          free_found;
  logic [SW-1:0] free_idx;
  logic [RW-1:0] row_w;
  logic [E-1:0]  low_bit;
  logic [SW-1:0] low_idx;

  assign busy     = (state != S_IDLE);
  assign period   = (ms_per_step == 16'd0) ? 16'd1 : ms_per_step;
  assign q_in     = (quant_reso == 8'd0) ? 8'd1 : quant_reso;
  assign loop_len = LW'(loop_bars * STEPS_PER_BAR);
  assign step_c   = div_rem[AW-1:0];
  assign low_bit  = mask & (~mask + 1'b1);

  always_comb begin
    if (bar_count == 4'd0) begin
      n_req = BW'(1);
    end else if (int'(bar_count) > MAX_BARS) begin
      n_req = BW'(MAX_BARS);
    end else begin
      n_req = BW'(bar_count);
    end
  end

  // first free slot of the row just read
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < E; i++) begin
      if (!free_found && !mem_rdata[i*SLOT_W + SLOT_ON]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
    row_w = mem_rdata;
    row_w[free_idx*SLOT_W +: SLOT_W] = {1'b1, freq_r, sample_r};
  end

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < E; i++) begin
      if (low_bit[i]) begin
        low_idx = SW'(i);
      end
    end
  end

  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    priority case (1'b1)
      state == S_IDLE: begin
        div_go  = start && (kind == KIND_TICK);
        div_num = NUM_W'(elapsed + 32'd1);
        div_den = DEN_W'(period);
      end
      state == S_RPREP: begin
        div_go  = 1'b1;
        div_num = NUM_W'({elapsed, 1'b0}) + NUM_W'(d_r);
        div_den = {d_r, 1'b0};
      end
      state == S_DIVQ: begin
        div_go  = div_done;
        div_num = op_tick ? div_quo : NUM_W'(div_quo[33:0] * q_r);
        div_den = DEN_W'(loop_len);
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = step_r;
    mem_wdata = row_w;
    mem_raddr = (state == S_COPYR) ? ci[AW-1:0] : step_c;
    if (state == S_READ && !op_tick) begin
      mem_we = free_found;
    end else if (state == S_COPYW) begin
      mem_we    = 1'b1;
      mem_waddr = base_r + ci[AW-1:0];
      mem_wdata = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      elapsed     <= '0;
      prev        <= '0;
      loop_bars   <= BW'(1);
      rec_count   <= '0;
      ms_per_step <= 16'd125;
      strobe      <= 1'b0;
    end else begin
      strobe <= (state == S_EMIT) && (mask != '0);
      if (cfg_we) begin
        ms_per_step <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_tick  <= (kind == KIND_TICK);
            q_r      <= q_in;
            freq_r   <= event_freq;
            sample_r <= event_sample;
            d_r      <= period * q_in;
            unique case (kind)
              KIND_TICK: begin
                elapsed <= elapsed + 32'd1;
                state   <= S_DIVQ;
              end
              KIND_START: begin
                elapsed <= '0;
              end
              KIND_REC: begin
                state <= S_RPREP;
              end
              KIND_BARS: begin
                loop_bars <= n_req;
                base_r    <= AW'(loop_bars * STEPS_PER_BAR);
                count_r   <= LW'((n_req - loop_bars) * STEPS_PER_BAR);
                ci        <= '0;
                if (loop_bars < n_req) begin
                  state <= S_COPYR;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RPREP: begin
          state <= S_DIVQ;
        end
        S_DIVQ: begin
          if (div_done) begin
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_done) begin
            step_r <= step_c;
            if (op_tick && step_c == prev) begin
              state <= S_IDLE;
            end else begin
              if (op_tick) begin
                prev <= step_c;
              end
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (op_tick) begin
            row_r <= mem_rdata;
            for (int i = 0; i < E; i++) begin
              mask[i] <= mem_rdata[i*SLOT_W + SLOT_ON];
            end
            state <= S_EMIT;
          end else begin
            if (free_found) begin
              if (rec_count == '0) begin
                elapsed <= '0;
                prev    <= '0;
              end
              if (rec_count != COUNT_MAX) begin
                rec_count <= rec_count + 16'd1;
              end
            end
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (mask == '0) begin
            state <= S_IDLE;
          end else begin
            note_freq   <= row_r[low_idx*SLOT_W + SAMPLE_W +: FREQ_W];
            note_sample <= row_r[low_idx*SLOT_W +: SAMPLE_W];
            last_of_run <= ((mask & ~low_bit) == '0);
            mask        <= mask & ~low_bit;
            if ((mask & ~low_bit) == '0) begin
              state <= S_IDLE;
            end
          end
        end
        S_COPYR: begin
          state <= S_COPYW;
        end
        S_COPYW: begin
          ci <= ci + 1'b1;
          if (ci + 1'b1 == count_r) begin
            state <= S_IDLE;
          end else begin
            state <= S_COPYR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lssr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  lssr_mem #(
    .ROWS (TOTAL),
    .AW   (AW),
    .RW   (RW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* src/lssr_div.sv */
// ----------------------------------------------------------------------------
// lssr_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lssr_div import lssr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !go && run && (cnt == CW'(NUM_W - 1));
      if (go) begin
        quo   <= num;
        rem   <= '0;
        den_r <= den;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/lssr_mem.sv */
// ----------------------------------------------------------------------------
// lssr_mem
// Event table: one row per step, registered read, row valid bits.
// ----------------------------------------------------------------------------
module lssr_mem import lssr_pkg::*; #(
  parameter int ROWS = 128,
  parameter int AW   = 7,
  parameter int RW   = 100
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [RW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [RW-1:0] rdata
);

  logic [RW-1:0] mem [ROWS];
  logic [ROWS-1:0] valid;
  logic [RW-1:0] mem_q;
  logic          valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  // never written rows read as cleared
  assign rdata = valid_q ? mem_q : '0;

endmodule

/* src/lssr_checker.sv */
// ----------------------------------------------------------------------------
// lssr_checker
// Port level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lssr_checker import lssr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind,
  input logic       strobe,
  input logic       last_of_run
);

  // notes of one run come in back to back
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_run |=> strobe)
    else $error("note run broken before last");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_run |-> busy)
    else $error("idle during note run");

  a_note_from_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("note without work");

  a_no_note_on_cmd: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind != KIND_TICK |=> !strobe)
    else $error("note after non-tick transfer");

endmodule

bind looping_step_sequencer_recorder lssr_checker u_lssr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .strobe      (strobe),
  .last_of_run (last_of_run)
);
